// File: hdl/blt_pkg.sv
package blt_pkg;

  // Default symbol width of the line code.
  localparam int BLT_SYMBOL_BITS = 5;

  // Configuration register widths and reset values.
  localparam int BIT_PERIOD_W      = 10;
  localparam int STOP_PERIOD_W     = 11;
  localparam int CFG_INDEX_W       = 2;
  localparam int CFG_DATA_W        = 11;
  localparam int BIT_PERIOD_RESET  = 22;
  localparam int STOP_PERIOD_RESET = 33;

  // Receiver sampling schedule, in ticks counted from the start tick.
  localparam int RX_START_SAMPLE_T = 10;
  localparam int RX_DATA_FIRST_T   = 25;
  localparam int RX_BIT_SPACING    = 20;
  localparam int RX_VOTE_OFF_A     = 0;
  localparam int RX_VOTE_OFF_B     = 5;
  localparam int RX_VOTE_OFF_C     = 10;
  localparam int RX_STOP_LEAD      = 30;
  localparam int RX_VOTE_W         = 2;
  localparam int RX_OFF_W          = $clog2(RX_BIT_SPACING);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BIT_PERIOD  = 2'd0,
    REG_STOP_PERIOD = 2'd1,
    REG_LOOPBACK    = 2'd2
  } blt_reg_t;

  // Per-word status from the transmitter.
  typedef struct packed {
    logic accepted;
    logic busy;
    logic level_set;
    logic level_val;
  } blt_tx_stat_t;

  // Per-word status from the receiver.
  typedef struct packed {
    logic sample;
    logic valid;
    logic ferr;
  } blt_rx_stat_t;

endpackage

// File: hdl/blt_if.sv
interface blt_in_if import blt_pkg::*; #(
  parameter int SYMBOL_BITS = BLT_SYMBOL_BITS
) ();
  logic                   valid;
  logic                   ready;
  logic                   line_in;
  logic                   send_valid;
  logic [SYMBOL_BITS-1:0] send_symbol;

  modport source (output valid, line_in, send_valid, send_symbol, input ready);
  modport sink   (input valid, line_in, send_valid, send_symbol, output ready);
endinterface

interface blt_out_if import blt_pkg::*; #(
  parameter int SYMBOL_BITS = BLT_SYMBOL_BITS
) ();
  logic                   valid;
  logic                   ready;
  logic                   line_out;
  logic                   send_accepted;
  logic                   sender_busy;
  logic                   recv_valid;
  logic [SYMBOL_BITS-1:0] recv_symbol;
  logic                   recv_framing_error;

  modport source (output valid, line_out, send_accepted, sender_busy, recv_valid,
                  recv_symbol, recv_framing_error, input ready);
  modport sink   (input valid, line_out, send_accepted, sender_busy, recv_valid,
                  recv_symbol, recv_framing_error, output ready);
endinterface

interface blt_cfg_if import blt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/blt_tx.sv
module blt_tx import blt_pkg::*; #(
  parameter int SYMBOL_BITS = BLT_SYMBOL_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic                     req,
  input  logic [SYMBOL_BITS-1:0]   sym,
  input  logic [BIT_PERIOD_W-1:0]  bit_period,
  input  logic [STOP_PERIOD_W-1:0] stop_period,
  output blt_tx_stat_t             stat
);

  localparam int IDX_W = $clog2(SYMBOL_BITS + 2);
  localparam logic [IDX_W-1:0] LAST_DATA = IDX_W'(SYMBOL_BITS);
  localparam logic [IDX_W-1:0] STOP_IDX  = IDX_W'(SYMBOL_BITS + 1);

  logic                     active_r, active_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [STOP_PERIOD_W-1:0] cnt_r, cnt_nxt;
  logic [SYMBOL_BITS-1:0]   shift_r, shift_nxt;
  logic [STOP_PERIOD_W-1:0] bit_len_m1;
  logic [STOP_PERIOD_W-1:0] stop_len_m1;

  // A zero period behaves as one tick.
  assign bit_len_m1 = (bit_period == '0) ? '0
                    : STOP_PERIOD_W'(bit_period - BIT_PERIOD_W'(1));
  assign stop_len_m1 = (stop_period == '0) ? '0 : stop_period - STOP_PERIOD_W'(1);

  always_comb begin
    active_nxt     = active_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    shift_nxt      = shift_r;
    stat.accepted  = 1'b0;
    stat.level_set = 1'b0;
    stat.level_val = 1'b0;
    if (active_r) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - STOP_PERIOD_W'(1);
      end else if (idx_r < LAST_DATA) begin
        idx_nxt        = idx_r + IDX_W'(1);
        stat.level_set = 1'b1;
        stat.level_val = ~shift_r[0];
        shift_nxt      = shift_r >> 1;
        cnt_nxt        = bit_len_m1;
      end else if (idx_r == LAST_DATA) begin
        idx_nxt        = STOP_IDX;
        stat.level_set = 1'b1;
        cnt_nxt        = stop_len_m1;
      end else begin
        active_nxt     = 1'b0;
        idx_nxt        = '0;
        stat.level_set = 1'b1;
      end
    end
    // A request on the tick the stop bit ends is taken on that same tick.
    if (req && !active_nxt) begin
      stat.accepted  = 1'b1;
      active_nxt     = 1'b1;
      idx_nxt        = '0;
      shift_nxt      = sym;
      stat.level_set = 1'b1;
      stat.level_val = 1'b1;
      cnt_nxt        = bit_len_m1;
    end
    stat.busy = active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
      cnt_r    <= '0;
      shift_r  <= '0;
    end else if (step) begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
      cnt_r    <= cnt_nxt;
      shift_r  <= shift_nxt;
    end
  end

endmodule

// File: hdl/blt_rx.sv
module blt_rx import blt_pkg::*; #(
  parameter int SYMBOL_BITS = BLT_SYMBOL_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic                   line,
  output blt_rx_stat_t           stat,
  output logic [SYMBOL_BITS-1:0] sym
);

  localparam int STOP_T   = RX_STOP_LEAD + RX_BIT_SPACING * SYMBOL_BITS;
  localparam int DATA_END = RX_DATA_FIRST_T + RX_BIT_SPACING * SYMBOL_BITS;
  localparam int CNT_W    = $clog2(STOP_T + 1);
  localparam int BIDX_W   = (SYMBOL_BITS > 1) ? $clog2(SYMBOL_BITS) : 1;

  logic                   active_r, active_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   start_r, start_nxt;
  logic [RX_VOTE_W-1:0]   votes_r, votes_nxt;
  logic [SYMBOL_BITS-1:0] bits_r, bits_nxt;
  logic [RX_OFF_W-1:0]    off_r, off_nxt;
  logic [BIDX_W-1:0]      bidx_r, bidx_nxt;
  logic [CNT_W-1:0]       tick;

  assign tick = cnt_r + CNT_W'(1);

  always_comb begin
    active_nxt  = active_r;
    cnt_nxt     = cnt_r;
    start_nxt   = start_r;
    votes_nxt   = votes_r;
    bits_nxt    = bits_r;
    off_nxt     = off_r;
    bidx_nxt    = bidx_r;
    stat.sample = 1'b0;
    stat.valid  = 1'b0;
    stat.ferr   = 1'b0;
    sym         = '0;
    if (!active_r) begin
      // Idle: every tick is a sample, and a high line starts a frame.
      stat.sample = 1'b1;
      if (line) begin
        active_nxt = 1'b1;
        cnt_nxt    = '0;
        votes_nxt  = '0;
        bits_nxt   = '0;
        start_nxt  = 1'b0;
      end
    end else begin
      cnt_nxt = tick;
      if (tick == CNT_W'(RX_START_SAMPLE_T)) begin
        stat.sample = 1'b1;
        start_nxt   = line;
      end else if (tick >= CNT_W'(RX_DATA_FIRST_T) && tick < CNT_W'(DATA_END)) begin
        // Position within the current data bit, tracked by a wrap counter.
        if (tick == CNT_W'(RX_DATA_FIRST_T)) begin
          off_nxt  = '0;
          bidx_nxt = '0;
        end else if (off_r == RX_OFF_W'(RX_BIT_SPACING - 1)) begin
          off_nxt  = '0;
          bidx_nxt = bidx_r + BIDX_W'(1);
        end else begin
          off_nxt = off_r + RX_OFF_W'(1);
        end
        if (off_nxt == RX_OFF_W'(RX_VOTE_OFF_A) || off_nxt == RX_OFF_W'(RX_VOTE_OFF_B) ||
            off_nxt == RX_OFF_W'(RX_VOTE_OFF_C)) begin
          stat.sample = 1'b1;
          if (!line) begin
            votes_nxt = votes_r + RX_VOTE_W'(1);
          end
          if (off_nxt == RX_OFF_W'(RX_VOTE_OFF_C)) begin
            if (votes_nxt >= RX_VOTE_W'(2)) begin
              bits_nxt = bits_r | (SYMBOL_BITS'(1) << bidx_nxt);
            end
            votes_nxt = '0;
          end
        end
      end else if (tick == CNT_W'(STOP_T)) begin
        stat.sample = 1'b1;
        stat.valid  = 1'b1;
        if (!start_r || line) begin
          stat.ferr = 1'b1;
        end else begin
          sym = bits_r;
        end
        active_nxt = 1'b0;
        cnt_nxt    = '0;
        votes_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
      start_r  <= 1'b0;
      votes_r  <= '0;
      bits_r   <= '0;
      off_r    <= '0;
      bidx_r   <= '0;
    end else if (step) begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
      start_r  <= start_nxt;
      votes_r  <= votes_nxt;
      bits_r   <= bits_nxt;
      off_r    <= off_nxt;
      bidx_r   <= bidx_nxt;
    end
  end

endmodule

// File: hdl/baudot_line_transceiver.sv
// Five-bit teletype line transceiver, advanced by one word per millisecond tick.
// Each input word on in_if carries the received line sample (line_in) and an
// optional transmit request (send_valid, send_symbol). Each input word yields
// exactly one output word on out_if with the transmit line level, whether the
// request was taken, the transmitter busy flag and, on the tick a received
// frame's stop sample is taken, the decoded symbol and framing error flag.
// The cfg_if channel writes the bit period, stop period and loopback enable;
// it is always ready and should only be used while the block is idle.
// Throughput is one word per clock cycle while out_if is ready: the word is
// captured in an input register, then the receiver and transmitter update and
// the result is loaded into the output register once that register is free.
// The input register and output register form a two-deep pipeline: when out_if
// stalls, one more word is still taken and held, then in_if.ready drops until
// the output drains. Synchronous reset (rst_n low) empties both registers,
// idles the receiver and transmitter, sets the kept line level low and
// restores the configuration defaults.
module baudot_line_transceiver import blt_pkg::*; #(
  parameter int SYMBOL_BITS = BLT_SYMBOL_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  blt_in_if.sink    in_if,
  blt_out_if.source out_if,
  blt_cfg_if.sink   cfg_if
);

  // Configuration registers.
  logic [BIT_PERIOD_W-1:0]  bit_period_r;
  logic [STOP_PERIOD_W-1:0] stop_period_r;
  logic                     loopback_r;

  // Input register.
  logic                   in_valid_r;
  logic                   line_r;
  logic                   req_r;
  logic [SYMBOL_BITS-1:0] sym_r;

  // Output register.
  logic                   out_valid_r;
  logic                   line_out_r;
  logic                   accepted_r;
  logic                   busy_r;
  logic                   rvalid_r;
  logic [SYMBOL_BITS-1:0] rsym_r;
  logic                   rerr_r;

  // Line level state, kept across words.
  logic out_level_r, out_level_nxt;

  logic                   advance;
  logic                   step;
  blt_tx_stat_t           tx_stat;
  blt_rx_stat_t           rx_stat;
  logic [SYMBOL_BITS-1:0] rx_sym;

  // The pipeline moves whenever the output register is empty or being drained.
  assign advance     = !out_valid_r || out_if.ready;
  assign step        = in_valid_r && advance;
  assign in_if.ready = !in_valid_r || advance;
  assign cfg_if.ready = 1'b1;

  blt_tx #(.SYMBOL_BITS(SYMBOL_BITS)) u_tx (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .req         (req_r),
    .sym         (sym_r),
    .bit_period  (bit_period_r),
    .stop_period (stop_period_r),
    .stat        (tx_stat)
  );

  blt_rx #(.SYMBOL_BITS(SYMBOL_BITS)) u_rx (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .line  (line_r),
    .stat  (rx_stat),
    .sym   (rx_sym)
  );

  // Loopback copies the sample onto the line on every receiver sample tick,
  // but only while the transmitter stays idle after this tick.
  always_comb begin
    if (rx_stat.sample && loopback_r && !tx_stat.busy) begin
      out_level_nxt = line_r;
    end else if (tx_stat.level_set) begin
      out_level_nxt = tx_stat.level_val;
    end else begin
      out_level_nxt = out_level_r;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      out_level_r   <= 1'b0;
      bit_period_r  <= BIT_PERIOD_W'(BIT_PERIOD_RESET);
      stop_period_r <= STOP_PERIOD_W'(STOP_PERIOD_RESET);
      loopback_r    <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (step) begin
        out_level_r <= out_level_nxt;
      end
      if (cfg_if.valid) begin
        unique case (blt_reg_t'(cfg_if.index))
          REG_BIT_PERIOD:  bit_period_r  <= cfg_if.data[BIT_PERIOD_W-1:0];
          REG_STOP_PERIOD: stop_period_r <= cfg_if.data[STOP_PERIOD_W-1:0];
          REG_LOOPBACK:    loopback_r    <= cfg_if.data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      line_r <= in_if.line_in;
      req_r  <= in_if.send_valid;
      sym_r  <= in_if.send_symbol;
    end
    if (step) begin
      line_out_r <= out_level_nxt;
      accepted_r <= tx_stat.accepted;
      busy_r     <= tx_stat.busy;
      rvalid_r   <= rx_stat.valid;
      rsym_r     <= rx_sym;
      rerr_r     <= rx_stat.ferr;
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.line_out           = line_out_r;
  assign out_if.send_accepted      = accepted_r;
  assign out_if.sender_busy        = busy_r;
  assign out_if.recv_valid         = rvalid_r;
  assign out_if.recv_symbol        = rsym_r;
  assign out_if.recv_framing_error = rerr_r;

endmodule

// File: hdl/blt_checker.sv
module blt_checker import blt_pkg::*; #(
  parameter int SYMBOL_BITS = BLT_SYMBOL_BITS
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   line_out,
  input logic                   send_accepted,
  input logic                   sender_busy,
  input logic                   recv_valid,
  input logic [SYMBOL_BITS-1:0] recv_symbol,
  input logic                   recv_framing_error
);

  // A stalled output word keeps its line level, receive valid and symbol.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(line_out) &&
      $stable(recv_symbol) && $stable(recv_valid))
    else $error("output word changed while stalled");

  // A framing error only comes with a completed frame and a cleared symbol.
  a_ferr_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && recv_framing_error |-> recv_valid && recv_symbol == '0)
    else $error("framing error without a clean completed frame");

  // A taken request always leaves the transmitter busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && send_accepted |-> sender_busy)
    else $error("request accepted but transmitter not busy");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind baudot_line_transceiver blt_checker #(.SYMBOL_BITS(SYMBOL_BITS)) u_blt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .line_out           (out_if.line_out),
  .send_accepted      (out_if.send_accepted),
  .sender_busy        (out_if.sender_busy),
  .recv_valid         (out_if.recv_valid),
  .recv_symbol        (out_if.recv_symbol),
  .recv_framing_error (out_if.recv_framing_error)
);

// File: sim/baudot_line_transceiver_tb.sv
`timescale 1ns / 100ps

module baudot_line_transceiver_tb;
  import blt_pkg::*;

  localparam int SYM_BITS = BLT_SYMBOL_BITS;

  // Receiver sampling schedule, counted in ticks from the tick that saw the
  // line go high while the receiver was idle.
  localparam int RX_T_START = 10;
  localparam int RX_T_DATA  = 25;
  localparam int RX_SPACING = 20;
  localparam int RX_VOTE_A  = 0;
  localparam int RX_VOTE_B  = 5;
  localparam int RX_VOTE_C  = 10;
  localparam int RX_T_STOP  = 30 + 20 * SYM_BITS;

  // Cycles without any accepted word before the run is declared hung. The
  // longest legal quiet stretch is the receiver hold-off of HOLD_CYCLES.
  localparam int HOLD_CYCLES = 300;
  localparam int STUCK_LIMIT = 3000;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 150;

  // One result word, in the order the block reports it.
  typedef struct packed {
    logic                line_out;
    logic                send_accepted;
    logic                sender_busy;
    logic                recv_valid;
    logic [SYM_BITS-1:0] recv_symbol;
    logic                recv_framing_error;
  } tick_result_t;

  // One row of the directed stimulus. When typed is set, want holds the
  // result written out by hand; otherwise the predictor supplies it.
  typedef struct {
    logic                line;
    logic                req;
    logic [SYM_BITS-1:0] sym;
    logic                typed;
    tick_result_t        want;
  } stim_row_t;

  localparam tick_result_t QUIET_TICK = '0;
  localparam tick_result_t SEND_START = '{line_out: 1'b1, send_accepted: 1'b1,
                                         sender_busy: 1'b1, default: '0};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  blt_in_if  #(.SYMBOL_BITS(SYM_BITS)) in_bus  ();
  blt_out_if #(.SYMBOL_BITS(SYM_BITS)) out_bus ();
  blt_cfg_if                           cfg_bus ();

  baudot_line_transceiver #(.SYMBOL_BITS(SYM_BITS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor state: the configuration as last written and the receiver
  // and transmitter state after the last accepted input word.
  // ---------------------------------------------------------------------
  logic [BIT_PERIOD_W-1:0]  cfg_bit_period;
  logic [STOP_PERIOD_W-1:0] cfg_stop_period;
  logic                     cfg_loop;

  logic                rx_on;
  logic [7:0]          rx_count;
  logic                rx_start_seen;
  logic [1:0]          rx_low_votes;
  logic [SYM_BITS-1:0] rx_data;
  logic                tx_on;
  logic [2:0]          tx_index;
  logic [10:0]         tx_left;
  logic [SYM_BITS-1:0] tx_shift;
  logic                line_level;

  // Results predicted for accepted input words, oldest first.
  tick_result_t predicted_words[$];
  stim_row_t    directed_rows[$];

  int mismatch_count = 0;
  int words_sent     = 0;
  int words_checked  = 0;
  int frames_seen    = 0;
  int ferr_seen      = 0;
  int sends_taken    = 0;
  int frames_shaped  = 0;
  int settings_done  = 0;

  // Sender and receiver pacing.
  int feed_calm  = 0;
  int hold_req   = 0;
  int hold_done  = 0;
  int drain_hold = 0;
  int drain_calm = 0;
  int stuck      = 0;

  function automatic void reset_model();
    cfg_bit_period  = BIT_PERIOD_W'(BIT_PERIOD_RESET);
    cfg_stop_period = STOP_PERIOD_W'(STOP_PERIOD_RESET);
    cfg_loop        = 1'b0;
    rx_on           = 1'b0;
    rx_count        = '0;
    rx_start_seen   = 1'b0;
    rx_low_votes    = '0;
    rx_data         = '0;
    tx_on           = 1'b0;
    tx_index        = '0;
    tx_left         = '0;
    tx_shift        = '0;
    line_level      = 1'b0;
  endfunction

  // A period register of zero behaves like one tick.
  function automatic logic [10:0] period_minus_one(input logic [10:0] p);
    return (p == 0) ? 11'd0 : p - 11'd1;
  endfunction

  // Advances the predictor by one tick and returns the result word.
  function automatic tick_result_t predict_tick(input logic line, input logic req,
                                                input logic [SYM_BITS-1:0] sym);
    tick_result_t r;
    logic         sampled;
    int           t;
    int           off;
    r       = '0;
    sampled = 1'b0;

    // Transmitter: start bit, inverted data bits LSB first, then stop bit.
    if (tx_on) begin
      if (tx_left != 0) begin
        tx_left = tx_left - 11'd1;
      end else if (tx_index < SYM_BITS) begin
        tx_index   = tx_index + 3'd1;
        line_level = ~tx_shift[0];
        tx_shift   = tx_shift >> 1;
        tx_left    = period_minus_one(11'(cfg_bit_period));
      end else if (tx_index == SYM_BITS) begin
        tx_index   = 3'(SYM_BITS + 1);
        line_level = 1'b0;
        tx_left    = period_minus_one(cfg_stop_period);
      end else begin
        tx_on      = 1'b0;
        tx_index   = '0;
        line_level = 1'b0;
      end
    end
    // A request on the tick the stop bit ends is taken on that same tick.
    if (req && !tx_on) begin
      r.send_accepted = 1'b1;
      tx_on           = 1'b1;
      tx_index        = '0;
      tx_shift        = sym;
      line_level      = 1'b1;
      tx_left         = period_minus_one(11'(cfg_bit_period));
    end

    // Receiver: idle until the line is high, then a fixed sampling schedule.
    if (!rx_on) begin
      sampled = 1'b1;
      if (line) begin
        rx_on         = 1'b1;
        rx_count      = '0;
        rx_low_votes  = '0;
        rx_data       = '0;
        rx_start_seen = 1'b0;
      end
    end else begin
      rx_count = rx_count + 8'd1;
      t        = int'(rx_count);
      if (t == RX_T_START) begin
        sampled       = 1'b1;
        rx_start_seen = line;
      end else if (t >= RX_T_DATA && t < RX_T_DATA + RX_SPACING * SYM_BITS) begin
        off = (t - RX_T_DATA) % RX_SPACING;
        if (off == RX_VOTE_A || off == RX_VOTE_B || off == RX_VOTE_C) begin
          sampled = 1'b1;
          if (!line) rx_low_votes = rx_low_votes + 2'd1;
          if (off == RX_VOTE_C) begin
            if (rx_low_votes >= 2) rx_data[(t - RX_T_DATA) / RX_SPACING] = 1'b1;
            rx_low_votes = '0;
          end
        end
      end else if (t == RX_T_STOP) begin
        sampled      = 1'b1;
        r.recv_valid = 1'b1;
        if (!rx_start_seen || line) r.recv_framing_error = 1'b1;
        else r.recv_symbol = rx_data;
        rx_on        = 1'b0;
        rx_count     = '0;
        rx_low_votes = '0;
      end
    end

    // Loopback echoes sampled levels only while the transmitter is idle.
    if (sampled && cfg_loop && !tx_on) line_level = line;

    r.line_out    = line_level;
    r.sender_busy = tx_on;
    return r;
  endfunction

  function automatic void add_row(input logic line, input logic req,
                                  input logic [SYM_BITS-1:0] sym, input logic typed,
                                  input tick_result_t want);
    stim_row_t row;
    row.line  = line;
    row.req   = req;
    row.sym   = sym;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------
  // Sender side. Each call offers one input word after a random gap, waits
  // for it to be taken and records the predicted result. Valid stays high
  // after acceptance so back-to-back words never toggle it within a step.
  // ---------------------------------------------------------------------
  task automatic drive_tick(input logic line, input logic req,
                            input logic [SYM_BITS-1:0] sym, input logic typed,
                            input tick_result_t typed_want);
    int           gap;
    int           pick;
    tick_result_t want;
    gap = 0;
    if (feed_calm > 0) begin
      feed_calm--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 50) gap = 0;
      else if (pick < 80) gap = $urandom_range(1, 3);
      else if (pick < 92) gap = $urandom_range(4, 12);
      else if (pick < 96) gap = $urandom_range(20, 60);
      else feed_calm = $urandom_range(30, 150);
    end
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.line_in     <= line;
    in_bus.send_valid  <= req;
    in_bus.send_symbol <= sym;
    do @(posedge clk); while (!in_bus.ready);
    want = predict_tick(line, req, sym);
    predicted_words.push_back(typed ? typed_want : want);
    words_sent++;
  endtask

  // One random tick on the given line level, with a transmit request now
  // and then so that sends land on every phase of the transmitter.
  task automatic feed_random(input logic line);
    logic req;
    req = ($urandom_range(0, 5) == 0);
    drive_tick(line, req, SYM_BITS'($urandom_range(0, 31)), 1'b0, QUIET_TICK);
  endtask

  // A receive frame shaped to the sampling schedule: high start, inverted
  // data bits, low stop. Some frames carry a bad start or stop level and
  // some vote samples are flipped to exercise the majority decision.
  task automatic run_frame();
    logic [SYM_BITS-1:0] code;
    int                  fault;
    int                  t;
    logic                lvl;
    code  = SYM_BITS'($urandom_range(0, 31));
    fault = $urandom_range(0, 9);
    while (rx_on) feed_random(1'b0);
    repeat ($urandom_range(0, 4)) feed_random(1'b0);
    for (t = 0; t <= RX_T_STOP; t++) begin
      if (t < RX_SPACING) lvl = 1'b1;
      else if (t < RX_SPACING * (SYM_BITS + 1)) lvl = ~code[(t - RX_SPACING) / RX_SPACING];
      else lvl = 1'b0;
      if (t == RX_T_START && fault == 0) lvl = 1'b0;
      if (t == RX_T_STOP && fault == 1) lvl = 1'b1;
      if (t >= RX_T_DATA && t < RX_T_STOP && (t - RX_T_DATA) % RX_VOTE_B == 0 &&
          $urandom_range(0, 9) == 0) lvl = ~lvl;
      feed_random(lvl);
    end
    frames_shaped++;
  endtask

  // Random line levels: glitches that start the receiver mid-stream.
  task automatic run_noise();
    repeat ($urandom_range(5, 30)) feed_random(1'(($urandom_range(0, 1))));
  endtask

  // Stops offering input and waits until every predicted word has come back,
  // so that registers can be written.
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (predicted_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input blt_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_BIT_PERIOD:  cfg_bit_period  = value[BIT_PERIOD_W-1:0];
      REG_STOP_PERIOD: cfg_stop_period = value[STOP_PERIOD_W-1:0];
      REG_LOOPBACK:    cfg_loop        = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] bit_p,
                               input logic [CFG_DATA_W-1:0] stop_p,
                               input logic [CFG_DATA_W-1:0] loop_en);
    write_reg(REG_BIT_PERIOD, bit_p);
    write_reg(REG_STOP_PERIOD, stop_p);
    write_reg(REG_LOOPBACK, loop_en);
    cfg_bus.valid <= 1'b0;
    settings_done++;
  endtask

  // ---------------------------------------------------------------------
  // Result side. Ready is paced at random, with calm stretches, short and
  // long stalls, and one long hold-off on request from the stimulus.
  // ---------------------------------------------------------------------
  function automatic void report_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void check_result(input tick_result_t got);
    tick_result_t want;
    if (predicted_words.size() == 0) begin
      $display("%0t: result word with nothing predicted, expected none, actual %h",
               $time, got);
      mismatch_count++;
    end else begin
      want = predicted_words.pop_front();
      report_field("line_out", want.line_out, got.line_out);
      report_field("send_accepted", want.send_accepted, got.send_accepted);
      report_field("sender_busy", want.sender_busy, got.sender_busy);
      report_field("recv_valid", want.recv_valid, got.recv_valid);
      report_field("recv_symbol", want.recv_symbol, got.recv_symbol);
      report_field("recv_framing_error", want.recv_framing_error,
                   got.recv_framing_error);
    end
    words_checked++;
    if (got.recv_valid) frames_seen++;
    if (got.recv_framing_error) ferr_seen++;
    if (got.send_accepted) sends_taken++;
  endfunction

  always @(posedge clk) begin
    tick_result_t got;
    int           pick;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.line_out           = out_bus.line_out;
      got.send_accepted      = out_bus.send_accepted;
      got.sender_busy        = out_bus.sender_busy;
      got.recv_valid         = out_bus.recv_valid;
      got.recv_symbol        = out_bus.recv_symbol;
      got.recv_framing_error = out_bus.recv_framing_error;
      check_result(got);
    end
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (drain_hold > 0) begin
      drain_hold--;
      out_bus.ready <= 1'b0;
    end else if (hold_req != hold_done) begin
      // Long hold-off: the input side keeps offering, so the block fills up
      // and has to drop in_if.ready.
      hold_done++;
      drain_hold = HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else if (drain_calm > 0) begin
      drain_calm--;
      out_bus.ready <= 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        out_bus.ready <= 1'b1;
      end else if (pick < 85) begin
        drain_hold = $urandom_range(0, 3);
        out_bus.ready <= 1'b0;
      end else if (pick < 90) begin
        drain_hold = $urandom_range(10, 40);
        out_bus.ready <= 1'b0;
      end else begin
        drain_calm = $urandom_range(20, 200);
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any accepted word on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
      $display("** baudot_line_transceiver: FAILED **");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    int phase;
    int start_count;
    in_bus.valid       <= 1'b0;
    in_bus.line_in     <= 1'b0;
    in_bus.send_valid  <= 1'b0;
    in_bus.send_symbol <= '0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= REG_BIT_PERIOD;
    cfg_bus.data       <= '0;
    reset_model();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Both periods are written as zero, which must act as one
    // tick, so a whole transmit frame is eight ticks: start, five data bits,
    // stop, and the end tick on which a new request is taken again.
    apply_setting(11'd0, 11'd0, 11'd0);
    add_row(1'b0, 1'b0, 5'd0,  1'b1, QUIET_TICK);   // idle, no request
    add_row(1'b0, 1'b1, 5'd31, 1'b1, SEND_START);   // all-ones symbol taken
    add_row(1'b0, 1'b1, 5'd0,  1'b0, QUIET_TICK);   // request while busy is dropped
    add_row(1'b0, 1'b0, 5'd0,  1'b0, QUIET_TICK);
    add_row(1'b0, 1'b1, 5'd7,  1'b0, QUIET_TICK);
    add_row(1'b0, 1'b0, 5'd0,  1'b0, QUIET_TICK);
    add_row(1'b0, 1'b0, 5'd0,  1'b0, QUIET_TICK);
    add_row(1'b0, 1'b0, 5'd0,  1'b0, QUIET_TICK);   // stop bit
    add_row(1'b0, 1'b1, 5'd0,  1'b0, QUIET_TICK);   // back-to-back, all-zeros symbol
    add_row(1'b0, 1'b0, 5'd0,  1'b0, QUIET_TICK);
    add_row(1'b0, 1'b1, 5'd31, 1'b0, QUIET_TICK);
    add_row(1'b0, 1'b0, 5'd0,  1'b0, QUIET_TICK);
    add_row(1'b0, 1'b0, 5'd0,  1'b0, QUIET_TICK);
    add_row(1'b0, 1'b0, 5'd0,  1'b0, QUIET_TICK);
    add_row(1'b0, 1'b0, 5'd0,  1'b0, QUIET_TICK);   // stop bit
    add_row(1'b0, 1'b0, 5'd0,  1'b0, QUIET_TICK);   // frame ends, nothing waiting
    add_row(1'b0, 1'b0, 5'd0,  1'b0, QUIET_TICK);   // transmitter idle
    add_row(1'b0, 1'b0, 5'd0,  1'b0, QUIET_TICK);
    add_row(1'b1, 1'b1, 5'd21, 1'b0, QUIET_TICK);   // line high starts the receiver
    add_row(1'b1, 1'b0, 5'd0,  1'b0, QUIET_TICK);
    add_row(1'b0, 1'b1, 5'd10, 1'b0, QUIET_TICK);
    add_row(1'b1, 1'b0, 5'd0,  1'b0, QUIET_TICK);
    add_row(1'b0, 1'b0, 5'd0,  1'b0, QUIET_TICK);
    add_row(1'b1, 1'b1, 5'd31, 1'b0, QUIET_TICK);
    foreach (directed_rows[i])
      drive_tick(directed_rows[i].line, directed_rows[i].req, directed_rows[i].sym,
                 directed_rows[i].typed, directed_rows[i].want);

    // Random part. Each phase first lets every predicted word come back, so
    // the sender has paused, then loads a new setting.
    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0:       apply_setting(11'd1, 11'd1, 11'd0);
        1:       apply_setting(CFG_DATA_W'(BIT_PERIOD_RESET),
                               CFG_DATA_W'(STOP_PERIOD_RESET), 11'd1);
        2:       apply_setting(11'd0, 11'd0, 11'd1);
        7:       apply_setting(11'd1000, 11'd2000, 11'd1);
        default: apply_setting(CFG_DATA_W'($urandom_range(1, 40)),
                               CFG_DATA_W'($urandom_range(1, 80)),
                               CFG_DATA_W'($urandom_range(0, 1)));
      endcase
      if (phase == 1) hold_req <= hold_req + 1;
      start_count = words_sent;
      while (words_sent - start_count < PHASE_WORDS) begin
        if ($urandom_range(0, 3) == 0) run_noise();
        else run_frame();
      end
    end

    in_bus.valid <= 1'b0;
    while (predicted_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d tick words over %0d settings, %0d shaped receive frames.",
             words_sent, settings_done, frames_shaped);
    $display("Checked %0d results: %0d frames received, %0d framing errors, %0d sends.",
             words_checked, frames_seen, ferr_seen, sends_taken);
    if (mismatch_count == 0) begin
      $display("** baudot_line_transceiver: PASSED **");
    end else begin
      $display("** baudot_line_transceiver: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/blt_pkg.sv
hdl/blt_if.sv
hdl/blt_tx.sv
hdl/blt_rx.sv
hdl/baudot_line_transceiver.sv
hdl/blt_checker.sv
sim/baudot_line_transceiver_tb.sv
